[design/sobel_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; imported by every module of the block.
package sobel_pkg;

  localparam int PIX_W       = 24;
  localparam int CH_W        = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_W_BITS  = 11;
  localparam int CFG_H_BITS  = 13;
  localparam int MAX_HEIGHT  = 4096;
  localparam int ROW_W       = 13;
  localparam int OROW_W      = 12;
  localparam int TAPS        = 9;
  localparam int GRAD_W      = 12;
  localparam int SQ_W        = 21;
  localparam int LANES       = 3;
  localparam int LANE_STAGES = 4;

  // smallest sum of squares whose rounded root exceeds 255
  localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65281;

  localparam logic signed [2:0] KERN_X [TAPS] = '{
    -3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1
  };
  localparam logic signed [2:0] KERN_Y [TAPS] = '{
    -3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1
  };

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic                  we;
    cfg_reg_e              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] ld;
  } lane_ctl_t;

endpackage

[design/sobel_line_buf.sv]
`timescale 1ns / 1ps
// Frame counters, two line stores and the 3x3 window of the Sobel block.
// Depends on sobel_pkg.
module sobel_line_buf
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic             win_valid_o,
  input  logic             win_ready_i,
  output logic [PIX_W-1:0] win_o [TAPS],
  output logic [TAPS-1:0]  mask_o,
  output logic             last_o
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

  logic [WW-1:0]         w_q;
  logic [CFG_H_BITS-1:0] h_q;
  int unsigned           w_cfg, h_cfg;

  logic [AW-1:0]     in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;

  logic acc, draining, take, emit, last, proceed;
  logic row_ok [3];
  logic col_ok [3];
  logic [TAPS-1:0] mask_d;

  logic              clr_busy_q;
  logic [AW-1:0]     clr_addr_q;
  logic [PIX_W-1:0]  upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [PIX_W-1:0]  up_wdata, mid_wdata, up_eff, mid_eff;
  logic [PIX_W-1:0]  up_rd_q, mid_rd_q;

  logic              a_v_q, fwd_q, a_emit_q, a_last_q;
  logic [PIX_W-1:0]  a_pix_q;
  logic [AW-1:0]     a_addr_q;
  logic [TAPS-1:0]   a_mask_q;

  logic              w_v_q, w_last_q;
  logic [TAPS-1:0]   w_mask_q;
  logic [PIX_W-1:0]  win_q [TAPS];

  always_comb begin
    w_cfg = 32'(cfg_i.data[CFG_W_BITS-1:0]);
    h_cfg = 32'(cfg_i.data[CFG_H_BITS-1:0]);
    if (w_cfg == 0) begin
      w_cfg = 1;
    end else if (w_cfg > MAX_WIDTH) begin
      w_cfg = MAX_WIDTH;
    end
    if (h_cfg == 0) begin
      h_cfg = 1;
    end else if (h_cfg > MAX_HEIGHT) begin
      h_cfg = MAX_HEIGHT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WW'(W_RST);
      h_q <= CFG_H_BITS'(480);
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        REG_FRAME_WIDTH:  w_q <= WW'(w_cfg);
        REG_FRAME_HEIGHT: h_q <= CFG_H_BITS'(h_cfg);
        default: ;
      endcase
    end
  end

  // intake: position bookkeeping and neighbour masks for the result
  assign proceed    = a_v_q && (!w_v_q || win_ready_i);
  assign in_stall_o = clr_busy_q || (a_v_q && !proceed);
  assign acc        = in_valid_i && !in_stall_o;
  assign draining   = in_row_q >= h_q;
  assign take       = !((op_i == OP_DRAIN) && !draining);
  assign emit       = (in_row_q >= ROW_W'(2)) ||
                      ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign last       = ({1'b0, out_row_q} == h_q - CFG_H_BITS'(1)) &&
                      (WW'(out_col_q) == w_q - WW'(1));

  always_comb begin
    row_ok[0] = out_row_q != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = {1'b0, out_row_q} != h_q - CFG_H_BITS'(1);
    col_ok[0] = out_col_q != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = WW'(out_col_q) != w_q - WW'(1);
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        mask_d[dr*3 + dc] = row_ok[dr] && col_ok[dc];
      end
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_i.we) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (acc && take) begin
      if (WW'(in_col_q) + WW'(1) >= w_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (WW'(out_col_q) + WW'(1) >= w_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + OROW_W'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // zero both line stores after reset, one column a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // a beat that reads the column just written takes the window's copy
  assign mid_eff   = fwd_q ? win_q[8] : mid_rd_q;
  assign up_eff    = fwd_q ? win_q[5] : up_rd_q;
  assign mem_we    = clr_busy_q || proceed;
  assign mem_addr  = clr_busy_q ? clr_addr_q : a_addr_q;
  assign up_wdata  = clr_busy_q ? '0 : mid_eff;
  assign mid_wdata = clr_busy_q ? '0 : a_pix_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[mem_addr]  <= up_wdata;
      middle_mem[mem_addr] <= mid_wdata;
    end
    if (acc) begin
      up_rd_q  <= upper_mem[in_col_q];
      mid_rd_q <= middle_mem[in_col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      fwd_q <= 1'b0;
    end else if (acc) begin
      a_v_q <= take;
      fwd_q <= take && proceed && (in_col_q == a_addr_q);
    end else if (proceed) begin
      a_v_q <= 1'b0;
      fwd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_pix_q  <= draining ? '0 : pix_i;
      a_addr_q <= in_col_q;
      a_emit_q <= emit;
      a_last_q <= last;
      a_mask_q <= mask_d;
    end
  end

  // window: shift left, load the new column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
      win_q <= '{default: '0};
    end else begin
      if (proceed) begin
        w_v_q    <= a_emit_q;
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= up_eff;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= mid_eff;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= a_pix_q;
      end else if (win_ready_i) begin
        w_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      w_mask_q <= a_mask_q;
      w_last_q <= a_last_q;
    end
  end

  assign win_valid_o = w_v_q;
  assign win_o       = win_q;
  assign mask_o      = w_mask_q;
  assign last_o      = w_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fwd_q |-> a_v_q)
    else $error("forward flag without an item in the read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni) WW'(in_col_q) < w_q)
    else $error("input column beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, out_row_q} < h_q) && (WW'(out_col_q) < w_q))
    else $error("result position outside the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !a_v_q && !w_v_q)
    else $error("item in flight while line stores are cleared");

endmodule

[design/sobel_lane.sv]
`timescale 1ns / 1ps
// One colour lane: Sobel gradients, sum of squares and a pipelined
// rounded square root saturated to 255. Depends on sobel_pkg.
module sobel_lane
  import sobel_pkg::*;
(
  input  logic            clk_i,
  input  lane_ctl_t       ctl_i,
  input  chan_t           tap_i [TAPS],
  input  logic [TAPS-1:0] mask_i,
  output chan_t           edge_o
);

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sq_st_t;

  function automatic sq_st_t sqrt_step(sq_st_t st, logic [1:0] pair);
    logic [10:0] t;
    logic [10:0] trial;
    logic [10:0] diff;
    sq_st_t      nx;
    t     = {st.rem, pair};
    trial = {1'b0, st.root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      nx.rem  = diff[8:0];
      nx.root = {st.root[6:0], 1'b1};
    end else begin
      nx.rem  = t[8:0];
      nx.root = {st.root[6:0], 1'b0};
    end
    return nx;
  endfunction

  logic signed [GRAD_W-1:0] v, gx_d, gy_d, gx_q, gy_q;
  logic [GRAD_W-2:0]        ax, ay;
  logic [2*GRAD_W-3:0]      px, py;
  logic [SQ_W-1:0]          sum_d, sum_q;
  sq_st_t                   hi_d, hi_q, lo_d;
  logic [7:0]               lo_byte_q;
  logic                     sat_q;
  chan_t                    edge_d, edge_q;

  always_comb begin
    gx_d = '0;
    gy_d = '0;
    for (int k = 0; k < TAPS; k++) begin
      v    = mask_i[k] ? GRAD_W'(tap_i[k]) : '0;
      gx_d = gx_d + v * GRAD_W'(KERN_X[k]);
      gy_d = gy_d + v * GRAD_W'(KERN_Y[k]);
    end
  end

  always_comb begin
    ax    = gx_q[GRAD_W-1] ? (GRAD_W-1)'(-gx_q) : gx_q[GRAD_W-2:0];
    ay    = gy_q[GRAD_W-1] ? (GRAD_W-1)'(-gy_q) : gy_q[GRAD_W-2:0];
    px    = ax * ax;
    py    = ay * ay;
    sum_d = SQ_W'(px) + SQ_W'(py);
  end

  always_comb begin
    hi_d = '0;
    for (int i = 0; i < 4; i++) begin
      hi_d = sqrt_step(hi_d, sum_q[15 - 2*i -: 2]);
    end
  end

  always_comb begin
    lo_d = hi_q;
    for (int i = 0; i < 4; i++) begin
      lo_d = sqrt_step(lo_d, lo_byte_q[7 - 2*i -: 2]);
    end
    if (sat_q) begin
      edge_d = '1;
    end else if (lo_d.rem > {1'b0, lo_d.root}) begin
      edge_d = lo_d.root + 8'd1;
    end else begin
      edge_d = lo_d.root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (ctl_i.ld[1]) begin
      sum_q <= sum_d;
    end
    if (ctl_i.ld[2]) begin
      hi_q      <= hi_d;
      lo_byte_q <= sum_q[7:0];
      sat_q     <= sum_q >= SAT_LIMIT;
    end
    if (ctl_i.ld[3]) begin
      edge_q <= edge_d;
    end
  end

  assign edge_o = edge_q;

endmodule

[design/sobel_merge.sv]
`timescale 1ns / 1ps
// Output register that joins the three lane results and the frame flag
// into one result beat. Depends on sobel_pkg.
module sobel_merge
  import sobel_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  logic  last_i,
  input  chan_t edge_i [LANES],
  output logic  ready_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output chan_t edge_red_o,
  output chan_t edge_green_o,
  output chan_t edge_blue_o,
  output logic  frame_last_o
);

  logic  out_valid_q, last_q;
  chan_t red_q, green_q, blue_q;

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      red_q   <= edge_i[0];
      green_q <= edge_i[1];
      blue_q  <= edge_i[2];
      last_q  <= last_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_red_o   = red_q;
  assign edge_green_o = green_q;
  assign edge_blue_o  = blue_q;
  assign frame_last_o = last_q;

endmodule

[design/sobel_edge_magnitude_rgb.sv]
`timescale 1ns / 1ps
// Sobel edge magnitude of an RGB raster stream, three colour lanes in parallel.
// Throughput one beat per cycle unless stalled; a result passes the read stage,
// window, lane stages and output register after the beat that completes its
// window (frame_width+1 beats later). The line stores take one registered read
// and one write per cycle, and after reset are cleared while input is stalled.
// Depends on sobel_pkg, sobel_line_buf, sobel_lane and sobel_merge.
module sobel_edge_magnitude_rgb
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [CH_W-1:0]       pixel_red_i,
  input  logic [CH_W-1:0]       pixel_green_i,
  input  logic [CH_W-1:0]       pixel_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       edge_red_o,
  output logic [CH_W-1:0]       edge_green_o,
  output logic [CH_W-1:0]       edge_blue_o,
  output logic                  frame_last_o
);

  cfg_wr_t                cfg;
  logic                   win_valid, win_last, merge_ready;
  logic [PIX_W-1:0]       win [TAPS];
  logic [TAPS-1:0]        win_mask;
  logic [LANE_STAGES-1:0] v_q, last_q, rdy;
  lane_ctl_t              ctl;
  chan_t                  taps [LANES][TAPS];
  chan_t                  lane_edge [LANES];

  assign cfg = '{we: cfg_we_i, index: cfg_reg_e'(cfg_index_i), data: cfg_data_i};

  sobel_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (operation_i),
    .pix_i      ({pixel_red_i, pixel_green_i, pixel_blue_i}),
    .win_valid_o(win_valid),
    .win_ready_i(rdy[0]),
    .win_o      (win),
    .mask_o     (win_mask),
    .last_o     (win_last)
  );

  // advance a lane stage when it is empty or its contents move on
  always_comb begin
    rdy[LANE_STAGES-1] = !v_q[LANE_STAGES-1] || merge_ready;
    for (int k = LANE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ctl.ld[0] = rdy[0] && win_valid;
    for (int k = 1; k < LANE_STAGES; k++) begin
      ctl.ld[k] = rdy[k] && v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= win_valid;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld[0]) begin
      last_q[0] <= win_last;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (ctl.ld[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      assign taps[c][k] = win[k][PIX_W-1-c*CH_W -: CH_W];
    end

    sobel_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .tap_i (taps[c]),
      .mask_i(win_mask),
      .edge_o(lane_edge[c])
    );
  end

  sobel_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_q[LANE_STAGES-1]),
    .last_i      (last_q[LANE_STAGES-1]),
    .edge_i      (lane_edge),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .edge_red_o  (edge_red_o),
    .edge_green_o(edge_green_o),
    .edge_blue_o (edge_blue_o),
    .frame_last_o(frame_last_o)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_rgb: a directed beat table, a held-back frame,
// part of the tallest frame, then random frames, scored against an in-bench predictor or typed table results.
// Depends on sobel_pkg and the block's RTL only.
module tb;
  import sobel_pkg::*;

  localparam int LINE_DEPTH    = 1024;
  localparam int ROW_CAP       = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 6000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BEATS  = 800;
  localparam int DIR_COUNT     = 29;
  localparam int GX_TAP [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int GY_TAP [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } edge_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    op_e                   op;
    chan_t                 red;
    chan_t                 green;
    chan_t                 blue;
    logic                  typed;
    edge_t                 want;
  } dir_row_t;

  localparam edge_t NO_EDGE = '0;

  // typed results: with a single row only the horizontal neighbour counts, |gx| = 2 * neighbour
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{1'b1, REG_FRAME_WIDTH,  13'd2, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b1, REG_FRAME_HEIGHT, 13'd1, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd255, 8'd255, 8'd255, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd100, 8'd10,  1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd60,  8'd1,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd77,  8'd77,  8'd77,  1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd255, 8'd120, 8'd2, 1'b0}},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd200, 8'd20, 1'b1}},
    '{1'b1, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b1, REG_FRAME_HEIGHT, 13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b1, REG_FRAME_WIDTH,  13'd3, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b1, REG_FRAME_HEIGHT, 13'd3, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd255, 8'd1,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd128, 8'd64,  8'd255, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd9,   8'd9,   8'd9,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd17,  8'd200, 8'd99,  1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd255, 8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd255, 1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_PIXEL, 8'd1,   8'd2,   8'd3,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE},
    '{1'b0, REG_FRAME_WIDTH,  13'd0, OP_DRAIN, 8'd0,   8'd0,   8'd0,   1'b0, NO_EDGE}
  };

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_index_i   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  operation_i   = 1'b0;
  logic [CH_W-1:0]       pixel_red_i   = '0;
  logic [CH_W-1:0]       pixel_green_i = '0;
  logic [CH_W-1:0]       pixel_blue_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [CH_W-1:0]       edge_red_o;
  logic [CH_W-1:0]       edge_green_o;
  logic [CH_W-1:0]       edge_blue_o;
  logic                  frame_last_o;

  logic [PIX_W-1:0]      upper_row_mem [LINE_DEPTH];
  logic [PIX_W-1:0]      mid_row_mem [LINE_DEPTH];
  logic [PIX_W-1:0]      tap_win [9];
  logic [CFG_W_BITS-1:0] width_reg;
  logic [CFG_H_BITS-1:0] height_reg;
  int                    in_col, in_row, out_col, out_row;
  edge_t                 pending_edges [$];

  int errors       = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_reqs    = 0;
  int hold_done    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int beats_sent   = 0;

  sobel_edge_magnitude_rgb uut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int frame_w();
    if (width_reg == '0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int frame_h();
    if (height_reg == '0) return 1;
    if (height_reg > ROW_CAP) return ROW_CAP;
    return int'(height_reg);
  endfunction

  function automatic void rewind_counters();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic chan_t grad_mag(int lsb, int w, int h);
    int          gx, gy, nr, nc, k, v, dr, dc, b;
    int unsigned sq, root;
    gx = 0;
    gy = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nr = out_row + dr;
        nc = out_col + dc;
        k  = (dr + 1) * 3 + dc + 1;
        if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
          v  = int'(tap_win[k][lsb +: CH_W]);
          gx += v * GX_TAP[k];
          gy += v * GY_TAP[k];
        end
      end
    end
    sq   = gx * gx + gy * gy;
    root = 0;
    for (b = 11; b >= 0; b--) begin
      if ((root | (1 << b)) * (root | (1 << b)) <= sq) root = root | (1 << b);
    end
    if (sq - root * root > root) root++;
    return (root > 255) ? 8'hFF : chan_t'(root);
  endfunction

  function automatic bit edge_step(op_e op, chan_t r, chan_t g, chan_t b, output edge_t res);
    int               w, h, col, k;
    logic [PIX_W-1:0] pix;
    bit               fire;
    w   = frame_w();
    h   = frame_h();
    res = NO_EDGE;
    if (op == OP_DRAIN && in_row < h) return 1'b0;
    pix = (in_row < h) ? {r, g, b} : '0;
    col = (in_col >= w) ? w - 1 : in_col;
    for (k = 0; k < 9; k += 3) begin
      tap_win[k]     = tap_win[k + 1];
      tap_win[k + 1] = tap_win[k + 2];
    end
    tap_win[2]         = upper_row_mem[col];
    tap_win[5]         = mid_row_mem[col];
    tap_win[8]         = pix;
    upper_row_mem[col] = mid_row_mem[col];
    mid_row_mem[col]   = pix;
    fire = in_row >= 2 || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!fire) return 1'b0;
    res.red   = grad_mag(16, w, h);
    res.green = grad_mag(8, w, h);
    res.blue  = grad_mag(0, w, h);
    res.last  = (out_row == h - 1 && out_col == w - 1);
    if (res.last) begin
      rewind_counters();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic chan_t rand_chan(bit harsh);
    if (harsh) return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
    return chan_t'($urandom);
  endfunction

  task automatic set_idle(int mode);
    case (mode)
      0: begin
        gap_pct   = 36;
        stall_pct = 76;
      end
      1: begin
        gap_pct   = 76;
        stall_pct = 36;
      end
      default: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_beat(op_e op, chan_t r, chan_t g, chan_t b,
                           bit typed = 1'b0, edge_t want = NO_EDGE);
    edge_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    pixel_red_i   <= r;
    pixel_green_i <= g;
    pixel_blue_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (edge_step(op, r, g, b, res)) pending_edges.push_back(typed ? want : res);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[CFG_W_BITS-1:0];
    else height_reg = val[CFG_H_BITS-1:0];
    rewind_counters();
  endtask

  task automatic send_frame(bit harsh, int cut);
    int w, h, n;
    w = frame_w();
    h = frame_h();
    for (n = 0; n < w * h; n++) begin
      if (n == cut) return;
      if ($urandom_range(19) == 0) begin
        send_beat(OP_DRAIN, rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
      end
      send_beat(OP_PIXEL, rand_chan(harsh), rand_chan(harsh), rand_chan(harsh));
      beats_sent++;
    end
    for (n = 0; n <= w; n++) begin
      if ($urandom_range(4) == 0) begin
        send_beat(OP_PIXEL, rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
      end else begin
        send_beat(OP_DRAIN, rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
      end
      beats_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    edge_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_edges.size() == 0) begin
        $error("edge beat with nothing pending: red %0d green %0d blue %0d last %0d",
               edge_red_o, edge_green_o, edge_blue_o, frame_last_o);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (edge_red_o !== want.red) begin
          $error("edge_red: expected %0d, got %0d", want.red, edge_red_o);
          errors++;
        end
        if (edge_green_o !== want.green) begin
          $error("edge_green: expected %0d, got %0d", want.green, edge_green_o);
          errors++;
        end
        if (edge_blue_o !== want.blue) begin
          $error("edge_blue: expected %0d, got %0d", want.blue, edge_blue_o);
          errors++;
        end
        if (frame_last_o !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, frame_last_o);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int i, cut;
    bit abandoned;
    abandoned  = 1'b0;
    width_reg  = 11'd640;
    height_reg = 13'd480;
    for (i = 0; i < LINE_DEPTH; i++) begin
      upper_row_mem[i] = '0;
      mid_row_mem[i]   = '0;
    end
    for (i = 0; i < 9; i++) tap_win[i] = '0;
    rewind_counters();
    set_idle(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].reg_val);
      end else begin
        send_beat(DIR_ROWS[i].op, DIR_ROWS[i].red, DIR_ROWS[i].green, DIR_ROWS[i].blue,
                  DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    // hold the output back through one frame, then send part of the tallest frame
    write_reg(REG_FRAME_WIDTH, 13'h1810);
    write_reg(REG_FRAME_HEIGHT, 13'd8);
    hold_reqs++;
    send_frame(1'b0, -1);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_frame(1'b1, 300);
    abandoned = 1'b1;

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      set_idle(beats_sent * 3 / RANDOM_BEATS);
      if (abandoned || $urandom_range(2) == 0) begin
        write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'($urandom_range(8))});
        write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(6)));
      end
      cut = ($urandom_range(7) == 0) ? int'($urandom_range(frame_w() * frame_h() - 1)) : -1;
      abandoned = (cut >= 0);
      send_frame($urandom_range(3) == 0, cut);
    end

    in_valid_i <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
